### design/ipv6pag_pkg.sv
// shared types and constants of the ipv6 prefix address generator
package ipv6pag_pkg;

    // address width and derived widths
    localparam int ADDR_BITS = 128;
    localparam int SHIFT_W   = $clog2(ADDR_BITS);
    localparam int IDX_W     = $clog2(ADDR_BITS);
    localparam int HALF_BITS = ADDR_BITS / 2;

    // reset value of every network, counter and base: ::1
    localparam logic [ADDR_BITS-1:0] ADDR_ONE = ADDR_BITS'(1);

    // action codes
    localparam logic [2:0] ACT_INIT      = 3'd0;
    localparam logic [2:0] ACT_GET_NET   = 3'd1;
    localparam logic [2:0] ACT_NEXT_NET  = 3'd2;
    localparam logic [2:0] ACT_GET_ADDR  = 3'd3;
    localparam logic [2:0] ACT_NEXT_ADDR = 3'd4;

    // input word
    typedef struct packed {
        logic [2:0]           action;
        logic [HALF_BITS-1:0] mask_hi;
        logic [HALF_BITS-1:0] mask_lo;
        logic [HALF_BITS-1:0] net_hi;
        logic [HALF_BITS-1:0] net_lo;
        logic [HALF_BITS-1:0] iid_hi;
        logic [HALF_BITS-1:0] iid_lo;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [HALF_BITS-1:0] addr_hi;
        logic [HALF_BITS-1:0] addr_lo;
        logic                 bad_prefix;
    } t_out_word;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the input word
        logic decode;  // find shift, slot index and mask check
        logic read;    // read the slot
        logic exec;    // compute, write back the slot, load the output word
    } t_ctl_cmd;

endpackage

### design/ipv6pag_ctrl.sv
// controller state machine of the ipv6 prefix address generator
module ipv6pag_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ipv6pag_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEC  = 4'b0010,
        S_RD   = 4'b0100,
        S_EX   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   exec_go;

    // the result may be loaded once the output register is free or draining
    assign exec_go = (r_state == S_EX) && (!r_out_vld || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output word valid flag
    always_comb begin
        n_out_vld = (r_out_vld && !i_out_ready) || exec_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // handshake and datapath commands
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.decode = (r_state == S_DEC);
    assign o_cmd.read   = (r_state == S_RD);
    assign o_cmd.exec   = exec_go;

endmodule

### design/ipv6pag_dp.sv
// datapath of the ipv6 prefix address generator: slot table, shifters, incrementers
module ipv6pag_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ipv6pag_pkg::t_ctl_cmd  i_cmd,
    input  ipv6pag_pkg::t_in_word  i_in_data,
    output ipv6pag_pkg::t_out_word o_out_data
);

    localparam int AB = ipv6pag_pkg::ADDR_BITS;
    localparam int SW = ipv6pag_pkg::SHIFT_W;
    localparam int IW = ipv6pag_pkg::IDX_W;
    localparam int HB = ipv6pag_pkg::HALF_BITS;

    // trailing zero count by halving search, valid for a nonzero value
    function automatic logic [SW-1:0] trail_zeros(input logic [AB-1:0] v);
        logic [AB-1:0] w;
        logic [SW-1:0] n;
        w = v;
        n = '0;
        for (int k = SW - 1; k >= 0; k--) begin
            if ((w & ({AB{1'b1}} >> (AB - (1 << k)))) == '0) begin
                n[k] = 1'b1;
                w    = w >> (1 << k);
            end
        end
        return n;
    endfunction

    // slot table: network in the upper half, counter in the lower half
    logic [2*AB-1:0] mem [AB];
    logic [AB-1:0]   r_vld;

    ipv6pag_pkg::t_in_word  r_in;
    ipv6pag_pkg::t_out_word r_out;
    logic [SW-1:0]   r_s;
    logic            r_bad;
    logic [2*AB-1:0] r_rd_data;
    logic            r_rd_vld;
    logic [AB-1:0]   r_base;

    logic [AB-1:0]   mask;
    logic [IW-1:0]   idx;
    logic [AB-1:0]   cur_net, cur_cnt, net_inc, sh_in, net_sh;
    logic [AB-1:0]   new_net, new_cnt, res, n_base;
    logic            wr_en;

    assign mask = {r_in.mask_hi, r_in.mask_lo};
    // slot index is ADDR_BITS minus the shift, taken modulo the depth
    assign idx  = IW'(AB) - IW'(r_s);

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
    end

    // mask decode
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_s   <= trail_zeros(mask);
            r_bad <= (mask == '0) || mask[0];
        end
    end

    // slot read, never-written slots read as ::1
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= mem[idx];
            r_rd_vld  <= r_vld[idx];
        end
    end

    assign cur_net = r_rd_vld ? r_rd_data[2*AB-1:AB] : ipv6pag_pkg::ADDR_ONE;
    assign cur_cnt = r_rd_vld ? r_rd_data[AB-1:0]    : ipv6pag_pkg::ADDR_ONE;
    assign net_inc = cur_net + ipv6pag_pkg::ADDR_ONE;
    assign sh_in   = (r_in.action == ipv6pag_pkg::ACT_NEXT_NET) ? net_inc : cur_net;
    assign net_sh  = sh_in << r_s;

    // action decode
    always_comb begin
        new_net = cur_net;
        new_cnt = cur_cnt;
        n_base  = r_base;
        res     = '0;
        wr_en   = 1'b0;
        if (!r_bad) begin
            case (r_in.action)
                ipv6pag_pkg::ACT_INIT: begin
                    new_net = {r_in.net_hi, r_in.net_lo} >> r_s;
                    new_cnt = {r_in.iid_hi, r_in.iid_lo};
                    n_base  = {r_in.iid_hi, r_in.iid_lo};
                    wr_en   = 1'b1;
                end
                ipv6pag_pkg::ACT_GET_NET: begin
                    res = net_sh;
                end
                ipv6pag_pkg::ACT_NEXT_NET: begin
                    new_net = net_inc;
                    new_cnt = r_base;
                    res     = net_sh;
                    wr_en   = 1'b1;
                end
                ipv6pag_pkg::ACT_GET_ADDR: begin
                    res = net_sh | cur_cnt;
                end
                ipv6pag_pkg::ACT_NEXT_ADDR: begin
                    res     = net_sh | cur_cnt;
                    new_cnt = cur_cnt + ipv6pag_pkg::ADDR_ONE;
                    wr_en   = 1'b1;
                end
                default: begin
                    res = '0;
                end
            endcase
        end
    end

    // slot write back
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[idx] <= {new_net, new_cnt};
        end
    end

    // slot valid bits and shared base id
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_base <= ipv6pag_pkg::ADDR_ONE;
        end else if (i_cmd.exec) begin
            r_base <= n_base;
            if (wr_en) begin
                r_vld[idx] <= 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out.addr_hi    <= res[AB-1:HB];
            r_out.addr_lo    <= res[HB-1:0];
            r_out.bad_prefix <= r_bad;
        end
    end

    assign o_out_data = r_out;

endmodule

### design/ipv6_prefix_address_generator.sv
// ipv6 address generator with one slot per prefix length: top level
// after input acceptance a word passes through the decode, slot read and execute states before output valid is set
// a new word is taken only once the previous one is through: capture, decode, slot read and execute run in turn
// the execute step waits while an earlier output word is still held and not taken
// reset (synchronous, active low) clears slot valid bits so every slot reads as ::1,
// and sets the base interface id to ::1; no clearing pass is needed
module ipv6_prefix_address_generator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  ipv6pag_pkg::t_in_word  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output ipv6pag_pkg::t_out_word o_out_data
);

    ipv6pag_pkg::t_ctl_cmd cmd;

    // sequencing
    ipv6pag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // slot table and arithmetic
    ipv6pag_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

### sim/tb_ipv6_prefix_address_generator.sv
// testbench of the ipv6 prefix address generator: directed table, random words, slot predictor
module tb_ipv6_prefix_address_generator;
    timeunit 1ns;
    timeprecision 1ps;

    // package items used here
    typedef ipv6pag_pkg::t_in_word  t_in_word;
    typedef ipv6pag_pkg::t_out_word t_out_word;
    localparam int ADDR_BITS = ipv6pag_pkg::ADDR_BITS;
    localparam int HALF_BITS = ipv6pag_pkg::HALF_BITS;
    localparam logic [ADDR_BITS-1:0] ADDR_ONE = ipv6pag_pkg::ADDR_ONE;
    localparam logic [2:0] ACT_INIT      = ipv6pag_pkg::ACT_INIT;
    localparam logic [2:0] ACT_GET_NET   = ipv6pag_pkg::ACT_GET_NET;
    localparam logic [2:0] ACT_NEXT_NET  = ipv6pag_pkg::ACT_NEXT_NET;
    localparam logic [2:0] ACT_GET_ADDR  = ipv6pag_pkg::ACT_GET_ADDR;
    localparam logic [2:0] ACT_NEXT_ADDR = ipv6pag_pkg::ACT_NEXT_ADDR;

    // action codes the block ignores
    localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
    localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
    localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;

    localparam int RANDOM_WORDS = 2000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 20;

    // handy masks and values
    localparam logic [ADDR_BITS-1:0] Z128      = '0;
    localparam logic [ADDR_BITS-1:0] ALL1      = {ADDR_BITS{1'b1}};
    localparam logic [ADDR_BITS-1:0] MASK_S1   = 128'h2;
    localparam logic [ADDR_BITS-1:0] MASK_S64  = 128'h1_0000_0000_0000_0000;
    localparam logic [ADDR_BITS-1:0] MASK_S127 = {1'b1, 127'b0};
    localparam logic [ADDR_BITS-1:0] MASK_UP64 = {64'hffff_ffff_ffff_ffff, 64'h0};
    localparam logic [ADDR_BITS-1:0] MASK_EVEN = ALL1 ^ 128'h1;

    // one directed row; typed rows carry their expected result
    typedef struct packed {
        logic [2:0]           act;
        logic [ADDR_BITS-1:0] mask;
        logic [ADDR_BITS-1:0] net;
        logic [ADDR_BITS-1:0] iid;
        logic                 typed;
        logic [ADDR_BITS-1:0] addr;
        logic                 bad;
    } t_dir_row;

    localparam int DIR_ROWS = 23;
    localparam t_dir_row DIR_TABLE [0:DIR_ROWS-1] = '{
        // untouched slots read as ::1
        '{ACT_GET_NET,    MASK_S1,   Z128, Z128, 1'b1, 128'h2,              1'b0},
        '{ACT_GET_ADDR,   MASK_S1,   Z128, Z128, 1'b1, 128'h3,              1'b0},
        '{ACT_NEXT_ADDR,  MASK_S127, Z128, Z128, 1'b1, MASK_S127 | 128'h1,  1'b0},
        '{ACT_GET_ADDR,   MASK_S127, Z128, Z128, 1'b1, MASK_S127 | 128'h2,  1'b0},
        '{ACT_NEXT_NET,   MASK_S64,  Z128, Z128, 1'b1, 128'h2 << 64,        1'b0},
        // bad masks: zero or lowest bit set
        '{ACT_GET_NET,    Z128,      Z128, Z128, 1'b1, Z128,                1'b1},
        '{ACT_INIT,       ALL1,      ALL1, ALL1, 1'b1, Z128,                1'b1},
        '{ACT_NEXT_ADDR,  128'h1,    ALL1, ALL1, 1'b1, Z128,                1'b1},
        // unknown actions
        '{ACT_UNUSED_LO,  MASK_S1,   ALL1, ALL1, 1'b1, Z128,                1'b0},
        '{ACT_UNUSED_HI,  Z128,      ALL1, ALL1, 1'b1, Z128,                1'b1},
        '{ACT_UNUSED_MID, ALL1,      ALL1, ALL1, 1'b1, Z128,                1'b1},
        // all-ones network and counter, then wrap
        '{ACT_INIT,       MASK_EVEN, ALL1, ALL1, 1'b1, Z128,                1'b0},
        '{ACT_GET_NET,    MASK_EVEN, Z128, Z128, 1'b0, Z128,                1'b0},
        '{ACT_NEXT_NET,   MASK_EVEN, Z128, Z128, 1'b0, Z128,                1'b0},
        '{ACT_NEXT_ADDR,  MASK_EVEN, Z128, Z128, 1'b0, Z128,                1'b0},
        '{ACT_NEXT_ADDR,  MASK_EVEN, Z128, Z128, 1'b0, Z128,                1'b0},
        // shortest prefix slot
        '{ACT_INIT,       MASK_S127, ALL1, Z128, 1'b1, Z128,                1'b0},
        '{ACT_GET_ADDR,   MASK_S127, Z128, Z128, 1'b0, Z128,                1'b0},
        '{ACT_NEXT_NET,   MASK_S127, Z128, Z128, 1'b0, Z128,                1'b0},
        // half-width prefix
        '{ACT_INIT,       MASK_S64,  128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210,
                                     128'h0f0f_0f0f_0f0f_0f0f_ffff_ffff_ffff_ffff,
                                                                  1'b1, Z128, 1'b0},
        '{ACT_NEXT_ADDR,  MASK_S64,  Z128, Z128, 1'b0, Z128,                1'b0},
        '{ACT_GET_NET,    MASK_UP64, Z128, Z128, 1'b0, Z128,                1'b0},
        '{ACT_NEXT_NET,   128'h4,    Z128, Z128, 1'b0, Z128,                1'b0}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_data;

    // predicted slot table and base interface id
    logic [ADDR_BITS-1:0] slot_net [0:ADDR_BITS-1];
    logic [ADDR_BITS-1:0] slot_cnt [0:ADDR_BITS-1];
    logic [ADDR_BITS-1:0] base_iid;

    t_out_word pending_words [$];
    int        err_cnt;
    int        words_sent;
    int        words_checked;
    int        bad_masks;
    int        ignored_words;
    int        cycle_cnt;
    bit        no_idle;

    ipv6_prefix_address_generator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // every slot and the base back to ::1
    function automatic void clear_slots();
        for (int k = 0; k < ADDR_BITS; k++) begin
            slot_net[k] = ADDR_ONE;
            slot_cnt[k] = ADDR_ONE;
        end
        base_iid = ADDR_ONE;
    endfunction

    // expected output word of one input word, updating the slot table
    function automatic t_out_word next_address(t_in_word w);
        logic [ADDR_BITS-1:0] mask;
        logic [ADDR_BITS-1:0] res;
        int                   tz;
        int                   slot;
        t_out_word            r;
        mask = {w.mask_hi, w.mask_lo};
        res  = '0;
        r    = '0;
        tz   = ADDR_BITS;
        for (int k = ADDR_BITS - 1; k >= 0; k--) begin
            if (mask[k]) tz = k;
        end
        if (tz == 0 || tz == ADDR_BITS) begin
            r.bad_prefix = 1'b1;
            return r;
        end
        slot = ADDR_BITS - tz;
        case (w.action)
            ACT_INIT: begin
                slot_net[slot] = {w.net_hi, w.net_lo} >> tz;
                slot_cnt[slot] = {w.iid_hi, w.iid_lo};
                base_iid       = {w.iid_hi, w.iid_lo};
            end
            ACT_GET_NET: begin
                res = slot_net[slot] << tz;
            end
            ACT_NEXT_NET: begin
                slot_cnt[slot] = base_iid;
                slot_net[slot] = slot_net[slot] + 1'b1;
                res = slot_net[slot] << tz;
            end
            ACT_GET_ADDR, ACT_NEXT_ADDR: begin
                res = (slot_net[slot] << tz) | slot_cnt[slot];
                if (w.action == ACT_NEXT_ADDR) slot_cnt[slot] = slot_cnt[slot] + 1'b1;
            end
            default: begin
            end
        endcase
        {r.addr_hi, r.addr_lo} = res;
        return r;
    endfunction

    function automatic logic [ADDR_BITS-1:0] rand_128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // random word: mostly good masks on a few busy slots, some bad masks and unknown actions
    function automatic t_in_word rand_word();
        t_in_word             w;
        logic [ADDR_BITS-1:0] mask;
        logic [ADDR_BITS-1:0] net;
        logic [ADDR_BITS-1:0] iid;
        int                   pick;
        int                   tz;
        pick = $urandom_range(99);
        if (pick < 3) begin
            mask = '0;
        end else if (pick < 8) begin
            mask = rand_128() | 128'h1;
        end else begin
            tz   = $urandom_range(1) ? $urandom_range(1, 6) : $urandom_range(1, ADDR_BITS - 1);
            mask = (rand_128() << tz) | (128'h1 << tz);
        end
        net = ($urandom_range(9) == 0) ? ALL1 : rand_128();
        iid = ($urandom_range(9) == 0) ? ALL1 - $urandom_range(3) : rand_128();
        w.action = ($urandom_range(99) < 5) ? 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI))
                                            : 3'($urandom_range(ACT_INIT, ACT_NEXT_ADDR));
        {w.mask_hi, w.mask_lo} = mask;
        {w.net_hi, w.net_lo}   = net;
        {w.iid_hi, w.iid_lo}   = iid;
        return w;
    endfunction

    // offer one word, predict on acceptance
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_res);
        t_out_word predicted;
        while (!no_idle && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = next_address(w);
        pending_words.push_back(typed ? typed_res : predicted);
        words_sent++;
        if (predicted.bad_prefix) bad_masks++;
        else if (w.action > ACT_NEXT_ADDR) ignored_words++;
        @(negedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off while the sender keeps offering
    initial begin
        int  held;
        bit  pressed;
        pressed     = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pressed && words_sent >= 300) begin
                pressed = 1'b1;
                i_out_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge i_clk);
            end
            i_out_ready <= (no_idle || $urandom_range(99) >= 6);
        end
    end

    // output check against the oldest expected word
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                $error("output word with nothing expected: %h", o_out_data);
                err_cnt++;
            end else begin
                exp_word = pending_words.pop_front();
                words_checked++;
                if (o_out_data.addr_hi !== exp_word.addr_hi) begin
                    $error("addr_hi expected %h actual %h", exp_word.addr_hi, o_out_data.addr_hi);
                    err_cnt++;
                end
                if (o_out_data.addr_lo !== exp_word.addr_lo) begin
                    $error("addr_lo expected %h actual %h", exp_word.addr_lo, o_out_data.addr_lo);
                    err_cnt++;
                end
                if (o_out_data.bad_prefix !== exp_word.bad_prefix) begin
                    $error("bad_prefix expected %b actual %b",
                           exp_word.bad_prefix, o_out_data.bad_prefix);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, pending_words.size());
            $display("tb_ipv6_prefix_address_generator NOT OK");
            $finish;
        end
    end

    // reset, directed table, random words, drain
    initial begin
        t_in_word  w;
        t_out_word typed_res;
        err_cnt       = 0;
        words_sent    = 0;
        words_checked = 0;
        bad_masks     = 0;
        ignored_words = 0;
        cycle_cnt     = 0;
        no_idle       = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        clear_slots();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int row = 0; row < DIR_ROWS; row++) begin
            w.action               = DIR_TABLE[row].act;
            {w.mask_hi, w.mask_lo} = DIR_TABLE[row].mask;
            {w.net_hi, w.net_lo}   = DIR_TABLE[row].net;
            {w.iid_hi, w.iid_lo}   = DIR_TABLE[row].iid;
            typed_res.addr_hi      = DIR_TABLE[row].addr[ADDR_BITS-1:HALF_BITS];
            typed_res.addr_lo      = DIR_TABLE[row].addr[HALF_BITS-1:0];
            typed_res.bad_prefix   = DIR_TABLE[row].bad;
            send_word(w, DIR_TABLE[row].typed, typed_res);
        end

        // random words, with a stretch where neither side idles
        typed_res = '0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            no_idle = (n >= 900 && n < 1200);
            send_word(rand_word(), 1'b0, typed_res);
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        // drain
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            $error("%0d expected words never arrived", pending_words.size());
            err_cnt++;
        end

        $display("sent %0d words (%0d bad masks, %0d unknown actions), checked %0d results",
                 words_sent, bad_masks, ignored_words, words_checked);
        $display("one %0d-cycle output hold-off, %0d mismatches", HOLD_CYCLES, err_cnt);
        if (err_cnt == 0) begin
            $display("tb_ipv6_prefix_address_generator OK");
        end else begin
            $display("tb_ipv6_prefix_address_generator NOT OK");
        end
        $finish;
    end

endmodule
